### hw/rtl/lprst_pkg.sv
package lprst_pkg;

    // Field widths of one request and one result beat
    localparam int REQ_W  = 2;
    localparam int REG_W  = 16;
    localparam int SLOT_W = 5;
    localparam int STAT_W = 2;
    localparam int PCNT_W = 6;

    // Home slot remainder: bits of the register number folded in per cycle
    localparam int HOME_DIG   = 4;
    localparam int HOME_STEPS = REG_W / HOME_DIG;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd2;
    localparam logic [REQ_W-1:0] REQ_INVAL = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_HIT  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FREE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd2;

    // Largest probe count the result field carries
    localparam logic [PCNT_W-1:0] PCNT_MAX = 6'd63;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HOME,
        ST_PROBE
    } t_state;

endpackage

### hw/rtl/lprst_ram.sv
module lprst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/lprst_home.sv
// Home slot: ((reg - 1) mod 2^16) mod SLOTS, four bits per cycle.
module lprst_home #(
    parameter int SLOTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lprst_pkg::REG_W-1:0]   i_reg,
    output logic                          o_done,
    output logic [$clog2(SLOTS)-1:0]      o_home
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(lprst_pkg::HOME_STEPS);
    localparam logic [IW:0]   SLOTS_V  = (IW+1)'(SLOTS);
    localparam logic [CW-1:0] LAST_CNT = CW'(lprst_pkg::HOME_STEPS - 1);

    logic [lprst_pkg::REG_W-1:0] r_val;
    logic [IW:0]                 r_rem;
    logic [CW-1:0]               r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [IW:0]                 n_rem;

    // Shift-subtract remainder; rem stays below SLOTS between steps
    always_comb begin
        n_rem = r_rem;
        for (int b = 0; b < lprst_pkg::HOME_DIG; b++) begin
            n_rem = {n_rem[IW-1:0], r_val[lprst_pkg::REG_W-1-b]};
            if (n_rem >= SLOTS_V) begin
                n_rem = n_rem - SLOTS_V;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_reg - 1'b1;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[lprst_pkg::REG_W-lprst_pkg::HOME_DIG-1:0],
                      {lprst_pkg::HOME_DIG{1'b0}}};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_home = r_rem[IW-1:0];

endmodule

### hw/rtl/linear_probe_register_slot_table.sv
// Timing: invalidate answers in the cycle after start; lookups and allocate answer after
//   home slot reduction and a probe walk from the home slot that ends at a match (or,
//   for write, a free slot) or after every slot. busy is high for that time.
// Throughput: one request at a time; the tag RAM gives one compare per cycle.
// Reset (synchronous, active low) clears all valid marks and the sequencer; tags are
//   not cleared. The result strobe is high for one cycle and cannot be stalled.
module linear_probe_register_slot_table #(
    parameter int SLOTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lprst_pkg::REQ_W-1:0]   i_req_type,
    input  logic [lprst_pkg::REG_W-1:0]   i_reg_number,
    input  logic [lprst_pkg::SLOT_W-1:0]  i_slot_to_clear,
    output logic                          o_strobe,
    output logic [lprst_pkg::STAT_W-1:0]  o_status,
    output logic [lprst_pkg::SLOT_W-1:0]  o_slot,
    output logic [lprst_pkg::PCNT_W-1:0]  o_probe_count
);

    localparam int IW = $clog2(SLOTS);
    localparam int SW = lprst_pkg::SLOT_W;
    localparam int PW = lprst_pkg::PCNT_W;
    localparam logic [IW-1:0]  LAST_IDX = IW'(SLOTS - 1);
    localparam logic [IW+SW-1:0] SLOTS_C = (IW+SW)'(SLOTS);
    // Probe count reported on a miss: SLOTS, saturated to the field
    localparam logic [PW-1:0]  PCNT_MISS = (SLOTS > 63) ? lprst_pkg::PCNT_MAX : PW'(SLOTS);

    // ------------------------------------------------------------------
    // Request acceptance
    // ------------------------------------------------------------------
    lprst_pkg::t_state r_state, n_state;

    logic acc;
    logic acc_inval;
    logic acc_probe;

    assign busy      = (r_state != lprst_pkg::ST_IDLE);
    assign acc       = start && !busy;
    assign acc_inval = acc && (i_req_type == lprst_pkg::REQ_INVAL);
    assign acc_probe = acc && (i_req_type != lprst_pkg::REQ_INVAL);

    // Invalidate index range check; slot_to_clear may exceed a small table
    logic [IW+SW-1:0] clr_ext;
    logic             clr_ok;
    assign clr_ext = {{IW{1'b0}}, i_slot_to_clear};
    assign clr_ok  = (clr_ext < SLOTS_C);

    // Latched request
    logic [lprst_pkg::REQ_W-1:0] r_req;
    logic [lprst_pkg::REG_W-1:0] r_reg;

    always_ff @(posedge i_clk) begin
        if (acc_probe) begin
            r_req <= i_req_type;
            r_reg <= i_reg_number;
        end
    end

    // ------------------------------------------------------------------
    // Home slot unit
    // ------------------------------------------------------------------
    logic          home_done;
    logic [IW-1:0] home_slot;

    lprst_home #(
        .SLOTS (SLOTS)
    ) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (acc_probe),
        .i_reg   (i_reg_number),
        .o_done  (home_done),
        .o_home  (home_slot)
    );

    // ------------------------------------------------------------------
    // Probe pipeline: issue stage drives the tag RAM read address, the
    // compare stage sees the tag in the next cycle with the valid mark that
    // was sampled alongside. The table only changes when a probe ends, so
    // no forwarding is needed inside a walk.
    // ------------------------------------------------------------------
    logic            r_issuing;
    logic [IW-1:0]   r_addr;
    logic [IW-1:0]   r_iss;

    logic            r_c_vld;
    logic [IW-1:0]   r_c_addr;
    logic [IW-1:0]   r_c_dist;
    logic            r_c_valid;

    // First free slot seen so far (only allocate uses it)
    logic            r_free_seen;
    logic [IW-1:0]   r_free_addr;
    logic [IW-1:0]   r_free_dist;

    logic [SLOTS-1:0]            r_valid;
    logic [lprst_pkg::REG_W-1:0] rd_tag;

    // Decision signals
    logic                         c_match;
    logic                         c_last;
    logic                         eff_free_seen;
    logic [IW-1:0]                eff_free_addr;
    logic [IW-1:0]                eff_free_dist;
    logic                         fin;
    logic                         fin_miss;
    logic [lprst_pkg::STAT_W-1:0] fin_status;
    logic [IW-1:0]                fin_addr;
    logic [IW-1:0]                fin_dist;
    logic                         alloc_we;

    // Result beat registers
    logic                         r_strobe;
    logic [lprst_pkg::STAT_W-1:0] r_status;
    logic [SW-1:0]                r_slot;
    logic [PW-1:0]                r_pcnt;

    lprst_ram #(
        .WIDTH (lprst_pkg::REG_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (alloc_we),
        .i_waddr (eff_free_addr),
        .i_wdata (r_reg),
        .i_raddr (r_addr),
        .o_rdata (rd_tag)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lprst_pkg::ST_IDLE: begin
                if (acc_probe) begin
                    n_state = lprst_pkg::ST_HOME;
                end
            end
            lprst_pkg::ST_HOME: begin
                if (home_done) begin
                    n_state = lprst_pkg::ST_PROBE;
                end
            end
            lprst_pkg::ST_PROBE: begin
                if (fin) begin
                    n_state = lprst_pkg::ST_IDLE;
                end
            end
            default: n_state = lprst_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Probe decision (outputs of the sequencer)
    // ------------------------------------------------------------------
    always_comb begin
        c_match       = r_c_valid && (rd_tag == r_reg);
        c_last        = (r_c_dist == LAST_IDX);
        eff_free_seen = r_free_seen;
        eff_free_addr = r_free_addr;
        eff_free_dist = r_free_dist;
        fin           = 1'b0;
        fin_miss      = 1'b0;
        fin_status    = lprst_pkg::STAT_MISS;
        fin_addr      = r_c_addr;
        fin_dist      = r_c_dist;
        alloc_we      = 1'b0;

        if (!r_free_seen && !r_c_valid) begin
            eff_free_seen = 1'b1;
            eff_free_addr = r_c_addr;
            eff_free_dist = r_c_dist;
        end

        if ((r_state == lprst_pkg::ST_PROBE) && r_c_vld) begin
            case (r_req)
                lprst_pkg::REQ_READ: begin
                    if (c_match) begin
                        fin        = 1'b1;
                        fin_status = lprst_pkg::STAT_HIT;
                    end else if (c_last) begin
                        fin      = 1'b1;
                        fin_miss = 1'b1;
                    end
                end
                lprst_pkg::REQ_WRITE: begin
                    // stops at the first free slot or the first match
                    if (!r_c_valid) begin
                        fin        = 1'b1;
                        fin_status = lprst_pkg::STAT_FREE;
                    end else if (c_match) begin
                        fin        = 1'b1;
                        fin_status = lprst_pkg::STAT_HIT;
                    end else if (c_last) begin
                        fin      = 1'b1;
                        fin_miss = 1'b1;
                    end
                end
                lprst_pkg::REQ_ALLOC: begin
                    // a match anywhere wins over the first free slot
                    if (c_match) begin
                        fin        = 1'b1;
                        fin_status = lprst_pkg::STAT_HIT;
                    end else if (c_last) begin
                        fin = 1'b1;
                        if (eff_free_seen) begin
                            fin_status = lprst_pkg::STAT_FREE;
                            fin_addr   = eff_free_addr;
                            fin_dist   = eff_free_dist;
                            alloc_we   = 1'b1;
                        end else begin
                            fin_miss = 1'b1;
                        end
                    end
                end
                default: begin
                    // invalidate never reaches the probe walk
                end
            endcase
        end
    end

    // Result field formatting: low slot bits, saturated probe count
    logic [IW+SW-1:0] fin_addr_ext;
    logic [IW+PW-1:0] fin_dist_ext;
    logic [SW-1:0]    fin_slot;
    logic [PW-1:0]    fin_pcnt;

    assign fin_addr_ext = {{SW{1'b0}}, fin_addr};
    assign fin_dist_ext = {{PW{1'b0}}, fin_dist};
    assign fin_slot     = fin_miss ? '0 : fin_addr_ext[SW-1:0];
    assign fin_pcnt     = fin_miss ? PCNT_MISS :
                          (fin_dist_ext > (IW+PW)'(lprst_pkg::PCNT_MAX)) ?
                          lprst_pkg::PCNT_MAX : fin_dist_ext[PW-1:0];

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lprst_pkg::ST_IDLE;
            r_issuing   <= 1'b0;
            r_c_vld     <= 1'b0;
            r_free_seen <= 1'b0;
            r_valid     <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= fin || acc_inval;

            if ((r_state == lprst_pkg::ST_HOME) && home_done) begin
                r_issuing   <= 1'b1;
                r_free_seen <= 1'b0;
                r_c_vld     <= 1'b0;
            end else if (r_state == lprst_pkg::ST_PROBE) begin
                if (fin) begin
                    r_issuing <= 1'b0;
                    r_c_vld   <= 1'b0;
                end else begin
                    r_c_vld <= r_issuing;
                    if (r_issuing && (r_iss == LAST_IDX)) begin
                        r_issuing <= 1'b0;
                    end
                    if (r_c_vld) begin
                        r_free_seen <= eff_free_seen;
                    end
                end
            end

            if (acc_inval && clr_ok) begin
                r_valid[clr_ext[IW-1:0]] <= 1'b0;
            end
            if (alloc_we) begin
                r_valid[eff_free_addr] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if ((r_state == lprst_pkg::ST_HOME) && home_done) begin
            r_addr <= home_slot;
            r_iss  <= '0;
        end else if ((r_state == lprst_pkg::ST_PROBE) && r_issuing) begin
            r_addr <= (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;
            r_iss  <= r_iss + 1'b1;
        end

        // compare stage tracks the issued address
        r_c_addr  <= r_addr;
        r_c_dist  <= r_iss;
        r_c_valid <= r_valid[r_addr];

        if (r_c_vld) begin
            r_free_addr <= eff_free_addr;
            r_free_dist <= eff_free_dist;
        end
    end

    // ------------------------------------------------------------------
    // Result beat
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (acc_inval) begin
            r_status <= clr_ok ? lprst_pkg::STAT_HIT : lprst_pkg::STAT_MISS;
            r_slot   <= clr_ok ? i_slot_to_clear : '0;
            r_pcnt   <= '0;
        end else if (fin) begin
            r_status <= fin_miss ? lprst_pkg::STAT_MISS : fin_status;
            r_slot   <= fin_slot;
            r_pcnt   <= fin_pcnt;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_probe_count = r_pcnt;

endmodule

### dv/tb_top.sv
module tb_top;

    // Field widths, taken from the package
    localparam int REQ_W  = lprst_pkg::REQ_W;
    localparam int REG_W  = lprst_pkg::REG_W;
    localparam int SLOT_W = lprst_pkg::SLOT_W;
    localparam int STAT_W = lprst_pkg::STAT_W;
    localparam int PCNT_W = lprst_pkg::PCNT_W;

    // Table size of the block under test; slot_to_clear is 5 bits, so with 32 slots
    // every invalidate lands in range.
    localparam int SLOTS = 32;

    // Rough number of request beats to generate.
    localparam int ITEMS = 950;

    // Gaps on the request side stop once this few beats remain queued.
    localparam int QUIET_TAIL = 100;

    // Cycles to watch for stray strobes after the last answer.
    localparam int DRAIN_CYCLES = SLOTS + 20;

    typedef struct {
        logic [REQ_W-1:0]  req_type;
        logic [REG_W-1:0]  reg_number;
        logic [SLOT_W-1:0] slot_to_clear;
    } t_slot_request;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [PCNT_W-1:0] probe_count;
    } t_slot_answer;

    // DUT ports; the driven inputs are known from time zero
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [REQ_W-1:0]    i_req_type = '0;
    logic [REG_W-1:0]    i_reg_number = '0;
    logic [SLOT_W-1:0]   i_slot_to_clear = '0;
    logic                o_strobe;
    logic [STAT_W-1:0]   o_status;
    logic [SLOT_W-1:0]   o_slot;
    logic [PCNT_W-1:0]   o_probe_count;

    // Request beats waiting to go out, and answers waiting to come back
    t_slot_request request_q[$];
    t_slot_answer  pending_answers[$];

    // Shadow copy of the slot table; empty after reset
    logic [REG_W-1:0] shadow_tag[SLOTS];
    logic             shadow_valid[SLOTS] = '{default: 1'b0};

    // Driver bookkeeping
    t_slot_request on_port;
    int            gap_left = 0;
    int            idle_pct = 0;
    int            accepted = 0;

    // Run statistics
    int mismatches = 0;
    int req_seen[4] = '{0, 0, 0, 0};
    int stat_seen[3] = '{0, 0, 0};

    linear_probe_register_slot_table #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_reg_number    (i_reg_number),
        .i_slot_to_clear (i_slot_to_clear),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_probe_count   (o_probe_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR @%0t: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Pack one answer; slot index keeps its low bits, probe count saturates.
    function automatic t_slot_answer make_answer(logic [STAT_W-1:0] st, int idx, int steps);
        t_slot_answer ans;
        ans.status      = st;
        ans.slot        = idx[SLOT_W-1:0];
        ans.probe_count = (steps > int'(lprst_pkg::PCNT_MAX)) ? lprst_pkg::PCNT_MAX :
                          steps[PCNT_W-1:0];
        return ans;
    endfunction

    // First valid slot holding this tag, walking from home; -1 if none.
    function automatic int find_tag(logic [REG_W-1:0] rn, int home, output int hops);
        int idx;
        idx  = home;
        hops = 0;
        for (int d = 0; d < SLOTS; d++) begin
            if (shadow_valid[idx] && shadow_tag[idx] == rn) begin
                hops = d;
                return idx;
            end
            idx = (idx + 1) % SLOTS;
        end
        return -1;
    endfunction

    // Answer to one request, updating the shadow table as the block would.
    function automatic t_slot_answer probe_slot_table(t_slot_request rq);
        logic [REG_W-1:0] wrapped;
        int               home;
        int               idx;
        int               hops;
        t_slot_answer     ans;
        wrapped = rq.reg_number - 16'd1;   // reg 0 wraps to 0xFFFF
        home    = int'(wrapped) % SLOTS;
        ans     = make_answer(lprst_pkg::STAT_MISS, 0, SLOTS);
        case (rq.req_type)
            lprst_pkg::REQ_READ: begin
                idx = find_tag(rq.reg_number, home, hops);
                if (idx >= 0) ans = make_answer(lprst_pkg::STAT_HIT, idx, hops);
            end
            lprst_pkg::REQ_WRITE: begin
                // stop at first free slot or matching tag, table untouched
                idx = home;
                for (int d = 0; d < SLOTS; d++) begin
                    if (!shadow_valid[idx]) begin
                        return make_answer(lprst_pkg::STAT_FREE, idx, d);
                    end
                    if (shadow_tag[idx] == rq.reg_number) begin
                        return make_answer(lprst_pkg::STAT_HIT, idx, d);
                    end
                    idx = (idx + 1) % SLOTS;
                end
            end
            lprst_pkg::REQ_ALLOC: begin
                idx = find_tag(rq.reg_number, home, hops);
                if (idx >= 0) begin
                    ans = make_answer(lprst_pkg::STAT_HIT, idx, hops);
                end else begin
                    idx = home;
                    for (int d = 0; d < SLOTS; d++) begin
                        if (!shadow_valid[idx]) begin
                            shadow_valid[idx] = 1'b1;
                            shadow_tag[idx]   = rq.reg_number;
                            return make_answer(lprst_pkg::STAT_FREE, idx, d);
                        end
                        idx = (idx + 1) % SLOTS;
                    end
                end
            end
            default: begin
                if (int'(rq.slot_to_clear) < SLOTS) begin
                    shadow_valid[rq.slot_to_clear] = 1'b0;
                    ans = make_answer(lprst_pkg::STAT_HIT, rq.slot_to_clear, 0);
                end else begin
                    ans = make_answer(lprst_pkg::STAT_MISS, 0, 0);
                end
            end
        endcase
        return ans;
    endfunction

    task automatic add_req(input logic [REQ_W-1:0] rt, input logic [REG_W-1:0] rn,
                           input logic [SLOT_W-1:0] sc);
        t_slot_request rq;
        rq.req_type      = rt;
        rq.reg_number    = rn;
        rq.slot_to_clear = sc;
        request_q = {request_q, rq};
    endtask

    // Mostly clustered register numbers: homes 0/8/16/24, six tags each, so
    // chains collide and hits are common. Some extremes and some fully random.
    function automatic logic [REG_W-1:0] pick_reg();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            1:       return REG_W'($urandom);
            default: return 16'(1 + 8 * $urandom_range(0, 3) + 32 * $urandom_range(0, 5));
        endcase
    endfunction

    // Driver: start is decided once per edge with a single NBA. A gap burst may
    // begin right at an accept, so it overlaps whatever phase the block is in.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                // request beat taken on this edge
                pending_answers = {pending_answers, probe_slot_table(on_port)};
                req_seen[on_port.req_type]++;
                accepted++;
                if (accepted % 80 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       idle_pct = 0;    // stretch with back-to-back beats
                        1:       idle_pct = 15;
                        default: idle_pct = 50;
                    endcase
                end
                if (request_q.size() > QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
                    gap_left = $urandom_range(1, 19);
            end
            if (start && busy) begin
                // hold the beat until the block takes it
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (request_q.size() != 0) begin
                on_port          = request_q.pop_front();
                start           <= 1'b1;
                i_req_type      <= on_port.req_type;
                i_reg_number    <= on_port.reg_number;
                i_slot_to_clear <= on_port.slot_to_clear;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: a strobe beat cannot be held off, so compare it on the edge it ends.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("answer with nothing pending, status", o_status, -1);
            end else begin
                t_slot_answer want;
                want = pending_answers.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_slot !== want.slot)
                    report_mismatch("slot", o_slot, want.slot);
                if (o_probe_count !== want.probe_count)
                    report_mismatch("probe_count", o_probe_count, want.probe_count);
                if (o_status <= lprst_pkg::STAT_MISS) stat_seen[o_status]++;
            end
        end
    end

    initial begin
        int kind;
        int pick;
        logic [REQ_W-1:0] rt;

        // Directed: empty table, wrap-around, register zero, holes in a chain,
        // extreme slots and tags.
        add_req(lprst_pkg::REQ_READ,  16'd1,     5'd0);   // empty table miss
        add_req(lprst_pkg::REQ_WRITE, 16'hFFFF,  5'd31);  // free at home 30
        add_req(lprst_pkg::REQ_ALLOC, 16'd1,     5'd0);   // slot 0
        add_req(lprst_pkg::REQ_ALLOC, 16'd33,    5'd0);   // collides, slot 1
        add_req(lprst_pkg::REQ_ALLOC, 16'd0,     5'd0);   // reg zero: home 31
        add_req(lprst_pkg::REQ_ALLOC, 16'd32,    5'd0);   // home 31, wraps to slot 2
        add_req(lprst_pkg::REQ_READ,  16'd32,    5'd0);   // hit across the wrap
        add_req(lprst_pkg::REQ_ALLOC, 16'd1,     5'd0);   // existing tag, hit
        add_req(lprst_pkg::REQ_WRITE, 16'd65,    5'd0);   // past three foreign tags
        add_req(lprst_pkg::REQ_WRITE, 16'd33,    5'd0);   // hit
        add_req(lprst_pkg::REQ_INVAL, 16'd0,     5'd1);   // hole in the chain
        add_req(lprst_pkg::REQ_READ,  16'd32,    5'd0);   // read skips the hole
        add_req(lprst_pkg::REQ_WRITE, 16'd32,    5'd0);   // write stops at the hole
        add_req(lprst_pkg::REQ_READ,  16'd33,    5'd0);   // cleared tag misses
        add_req(lprst_pkg::REQ_ALLOC, 16'hFFFF,  5'd31);
        add_req(lprst_pkg::REQ_ALLOC, 16'h8000,  5'd31);  // refills the hole
        add_req(lprst_pkg::REQ_INVAL, 16'hFFFF,  5'd31);
        add_req(lprst_pkg::REQ_INVAL, 16'h0000,  5'd0);
        add_req(lprst_pkg::REQ_READ,  16'd0,     5'd0);
        add_req(lprst_pkg::REQ_INVAL, 16'd0,     5'd30);
        add_req(lprst_pkg::REQ_INVAL, 16'd0,     5'd2);
        add_req(lprst_pkg::REQ_INVAL, 16'd0,     5'd1);

        // Random sequences: mostly mixed traffic on colliding tags, some
        // fill-to-full runs with drains, some pure noise.
        while (request_q.size() < ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                repeat ($urandom_range(20, 60)) begin
                    pick = $urandom_range(0, 99);
                    rt = (pick < 35) ? lprst_pkg::REQ_ALLOC :
                         (pick < 60) ? lprst_pkg::REQ_READ :
                         (pick < 80) ? lprst_pkg::REQ_WRITE : lprst_pkg::REQ_INVAL;
                    add_req(rt, pick_reg(), SLOT_W'($urandom_range(0, SLOTS - 1)));
                end
            end else if (kind == 8) begin
                // fill the table, poke it while full, then drain
                repeat (SLOTS + 4) add_req(lprst_pkg::REQ_ALLOC,
                                           REG_W'($urandom_range(1, 65535)),
                                           SLOT_W'($urandom));
                add_req(lprst_pkg::REQ_READ,  REG_W'($urandom_range(1, 65535)),
                        SLOT_W'($urandom));
                add_req(lprst_pkg::REQ_WRITE, REG_W'($urandom_range(1, 65535)),
                        SLOT_W'($urandom));
                add_req(lprst_pkg::REQ_WRITE, pick_reg(), SLOT_W'($urandom));
                add_req(lprst_pkg::REQ_ALLOC, REG_W'($urandom_range(1, 65535)),
                        SLOT_W'($urandom));
                if ($urandom_range(0, 1)) begin
                    for (int s = 0; s < SLOTS; s++)
                        add_req(lprst_pkg::REQ_INVAL, REG_W'($urandom), SLOT_W'(s));
                end else begin
                    repeat ($urandom_range(4, 12))
                        add_req(lprst_pkg::REQ_INVAL, REG_W'($urandom), SLOT_W'($urandom));
                end
            end else begin
                repeat ($urandom_range(5, 15))
                    add_req(REQ_W'($urandom), REG_W'($urandom), SLOT_W'($urandom));
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all beats handed over, then all answers back, then a quiet window
        while (request_q.size() != 0 || start || gap_left != 0) @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d read, %0d write, %0d allocate, %0d invalidate",
                 accepted, req_seen[lprst_pkg::REQ_READ], req_seen[lprst_pkg::REQ_WRITE],
                 req_seen[lprst_pkg::REQ_ALLOC], req_seen[lprst_pkg::REQ_INVAL]);
        $display("Answers seen: %0d hit, %0d free or allocated, %0d miss or full; %0d errors",
                 stat_seen[lprst_pkg::STAT_HIT], stat_seen[lprst_pkg::STAT_FREE],
                 stat_seen[lprst_pkg::STAT_MISS], mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: a run still going at this delay ends as a mismatch.
    initial begin
        #4_000_000;
        $display("Timeout with %0d requests queued, %0d answers pending",
                 request_q.size(), pending_answers.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/lprst_pkg.sv
hw/rtl/lprst_ram.sv
hw/rtl/lprst_home.sv
hw/rtl/linear_probe_register_slot_table.sv
dv/tb_top.sv
